// File: rtl/sorted_insert_priority_queue_unit_defines.svh
// Assertion macros shared by the queue modules.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication under reset.
`define SIPQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication under reset.
`define SIPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define SIPQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SIPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: rtl/spq_pkg.sv
package spq_pkg;

	// Queue geometry and field widths.
	localparam int QUEUE_DEPTH  = 16;
	localparam int KEY_WIDTH    = 16;
	localparam int TAG_WIDTH    = 8;
	localparam int IDX_W        = $clog2(QUEUE_DEPTH);
	localparam int FILL_W       = 5;
	localparam int SLOT_FIELD_W = 5;
	localparam int STATUS_W     = 2;

	// Command codes.
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_CLEARED  = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} ctrl_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;
		logic commit;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic full;
		logic empty;
		logic pending_clear;
	} dp_status_t;

endpackage

// File: rtl/spq_in_if.sv
interface spq_in_if import spq_pkg::*; ();

	logic                        valid;
	logic                        ready;
	logic                        cmd;
	logic signed [KEY_WIDTH-1:0] entry_key;
	logic [TAG_WIDTH-1:0]        entry_tag;

	modport source (output valid, output cmd, output entry_key, output entry_tag,
		input ready);
	modport sink (input valid, input cmd, input entry_key, input entry_tag,
		output ready);

endinterface

// File: rtl/spq_out_if.sv
interface spq_out_if import spq_pkg::*; ();

	logic                        valid;
	logic                        ready;
	logic [STATUS_W-1:0]         status;
	logic [SLOT_FIELD_W-1:0]     slot;
	logic [FILL_W-1:0]           fill_count;
	logic                        head_valid;
	logic signed [KEY_WIDTH-1:0] head_key;
	logic [TAG_WIDTH-1:0]        head_tag;

	modport source (output valid, output status, output slot, output fill_count,
		output head_valid, output head_key, output head_tag, input ready);
	modport sink (input valid, input status, input slot, input fill_count,
		input head_valid, input head_key, input head_tag, output ready);

endinterface

// File: rtl/spq_ctrl.sv
`include "sorted_insert_priority_queue_unit_defines.svh"

module spq_ctrl import spq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output dp_cmd_t    dp_cmd,
	input  dp_status_t dp_status
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	logic        out_valid_q;
	logic        out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Next state: capture one transaction, then commit it once the result slot is free.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs: handshake and datapath commands.
	always_comb begin
		in_ready       = 1'b0;
		dp_cmd.capture = 1'b0;
		dp_cmd.commit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready       = 1'b1;
				dp_cmd.capture = in_valid;
			end
			ST_EXEC: begin
				dp_cmd.commit = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Hold state and the result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (dp_cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	`SIPQ_ASSERT_NEXT(a_accept_to_exec, clk, arst_n, in_valid && in_ready, state_q == ST_EXEC)
	`SIPQ_ASSERT_NEXT(a_result_held, clk, arst_n, out_valid_q && !out_ready, out_valid_q)
	`SIPQ_ASSERT_NEXT(a_clear_empties, clk, arst_n, dp_cmd.commit && dp_status.pending_clear, dp_status.empty)
	`SIPQ_ASSERT_NEXT(a_insert_fills, clk, arst_n, dp_cmd.commit && !dp_status.pending_clear && !dp_status.full, !dp_status.empty)

endmodule

// File: rtl/spq_datapath.sv
`include "sorted_insert_priority_queue_unit_defines.svh"

module spq_datapath import spq_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dp_cmd_t                     dp_cmd,
	output dp_status_t                  dp_status,
	input  logic                        in_cmd,
	input  logic signed [KEY_WIDTH-1:0] in_key,
	input  logic [TAG_WIDTH-1:0]        in_tag,
	output logic [STATUS_W-1:0]         res_status,
	output logic [SLOT_FIELD_W-1:0]     res_slot,
	output logic [FILL_W-1:0]           res_fill,
	output logic                        res_head_valid,
	output logic signed [KEY_WIDTH-1:0] res_head_key,
	output logic [TAG_WIDTH-1:0]        res_head_tag
);

	// Captured transaction.
	logic                        cmd_q;
	logic signed [KEY_WIDTH-1:0] key_in_q;
	logic [TAG_WIDTH-1:0]        tag_in_q;

	// Sorted entry cells and fill count.
	logic signed [KEY_WIDTH-1:0] key_q [QUEUE_DEPTH];
	logic [TAG_WIDTH-1:0]        tag_q [QUEUE_DEPTH];
	logic [FILL_W-1:0]           count_q;

	logic signed [KEY_WIDTH-1:0] key_nxt [QUEUE_DEPTH];
	logic [TAG_WIDTH-1:0]        tag_nxt [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]      le;
	logic [IDX_W-1:0]            pos;
	logic                        full;
	logic                        do_clear;
	logic                        do_insert;
	logic [FILL_W-1:0]           count_nxt;

	// Result register.
	logic [STATUS_W-1:0]         status_q;
	logic [SLOT_FIELD_W-1:0]     slot_q;
	logic [FILL_W-1:0]           fill_q;
	logic                        head_valid_q;
	logic signed [KEY_WIDTH-1:0] head_key_q;
	logic [TAG_WIDTH-1:0]        head_tag_q;

	assign full      = (count_q == FILL_W'(QUEUE_DEPTH));
	assign do_clear  = (cmd_q == CMD_CLEAR);
	assign do_insert = !do_clear && !full;

	assign dp_status.full          = full;
	assign dp_status.empty         = (count_q == '0);
	assign dp_status.pending_clear = do_clear;

	// Mark every held entry whose key does not exceed the new one (a prefix).
	// Each cell then keeps, takes the new entry, or takes its left neighbour.
	genvar g;
	generate
		for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
			assign le[g] = (count_q > FILL_W'(g)) && (key_q[g] <= key_in_q);
			if (g == 0) begin : g_head
				assign key_nxt[g] = le[g] ? key_q[g] : key_in_q;
				assign tag_nxt[g] = le[g] ? tag_q[g] : tag_in_q;
			end else begin : g_body
				assign key_nxt[g] = le[g] ? key_q[g] : (le[g-1] ? key_in_q : key_q[g-1]);
				assign tag_nxt[g] = le[g] ? tag_q[g] : (le[g-1] ? tag_in_q : tag_q[g-1]);
			end
		end
	endgenerate

	// Find the insert position: the first cell not marked.
	always_comb begin
		pos = '0;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (!le[i]) pos = IDX_W'(i);
		end
	end

	// Count after this transaction.
	always_comb begin
		if (do_clear) count_nxt = '0;
		else if (do_insert) count_nxt = count_q + FILL_W'(1);
		else count_nxt = count_q;
	end

	// Capture the accepted transaction.
	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			cmd_q    <= in_cmd;
			key_in_q <= in_key;
			tag_in_q <= in_tag;
		end
	end

	// Shift the cells on an insert.
	always_ff @(posedge clk) begin
		if (dp_cmd.commit && do_insert) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				key_q[i] <= key_nxt[i];
				tag_q[i] <= tag_nxt[i];
			end
		end
	end

	// Advance the fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (dp_cmd.commit) begin
			count_q <= count_nxt;
		end
	end

	// Load the result register.
	always_ff @(posedge clk) begin
		if (dp_cmd.commit) begin
			fill_q       <= count_nxt;
			head_valid_q <= (count_nxt != '0);
			if (do_clear) begin
				status_q <= STATUS_CLEARED;
				slot_q   <= '0;
			end else if (full) begin
				status_q <= STATUS_DROPPED;
				slot_q   <= '0;
			end else begin
				status_q <= STATUS_INSERTED;
				slot_q   <= SLOT_FIELD_W'(pos);
			end
			if (count_nxt == '0) begin
				head_key_q <= '0;
				head_tag_q <= '0;
			end else if (do_insert) begin
				head_key_q <= key_nxt[0];
				head_tag_q <= tag_nxt[0];
			end else begin
				head_key_q <= key_q[0];
				head_tag_q <= tag_q[0];
			end
		end
	end

	assign res_status     = status_q;
	assign res_slot       = slot_q;
	assign res_fill       = fill_q;
	assign res_head_valid = head_valid_q;
	assign res_head_key   = head_key_q;
	assign res_head_tag   = head_tag_q;

	`SIPQ_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= FILL_W'(QUEUE_DEPTH))
	`SIPQ_ASSERT_NEXT(a_insert_counts, clk, arst_n, dp_cmd.commit && do_insert, count_q == $past(count_q) + FILL_W'(1))
	`SIPQ_ASSERT_IMP(a_head_sorted, clk, arst_n, count_q >= FILL_W'(2), key_q[0] <= key_q[1])

endmodule

// File: rtl/sorted_insert_priority_queue_unit.sv
// Sorted priority queue with stable insert: up to 16 entries (signed key, tag) are kept in
// ascending key order, slot 0 being the most urgent; a new entry goes after every held entry
// with an equal or smaller key, a clear empties the queue, and an insert into a full queue is
// dropped. Every request transaction yields exactly one result transaction with the status,
// the slot used, the fill count after the request and the head entry (zero when empty). Each
// request is captured in the idle state and then committed in the exec state, in which all cells
// compare against the new key in parallel and shift right of the insert point, while the result
// register is loaded. The next request is captured while a result still waits to be taken; the
// commit cycle waits only while that result register is still full. The store needs no clearing
// after reset.
module sorted_insert_priority_queue_unit import spq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	spq_in_if.sink     req,
	spq_out_if.source  rsp
);

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.dp_cmd    (dp_cmd),
		.dp_status (dp_status)
	);

	spq_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.dp_cmd         (dp_cmd),
		.dp_status      (dp_status),
		.in_cmd         (req.cmd),
		.in_key         (req.entry_key),
		.in_tag         (req.entry_tag),
		.res_status     (rsp.status),
		.res_slot       (rsp.slot),
		.res_fill       (rsp.fill_count),
		.res_head_valid (rsp.head_valid),
		.res_head_key   (rsp.head_key),
		.res_head_tag   (rsp.head_tag)
	);

endmodule

// File: tb/sorted_queue_checker.sv
`timescale 1ns / 1ps

module sorted_queue_checker import spq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	spq_in_if    req,
	spq_out_if   rsp,
	output int   mismatch_count,
	output int   outstanding,
	output int   inserts_seen,
	output int   drops_seen,
	output int   clears_seen
);

	typedef struct packed {
		logic [STATUS_W-1:0]         status;
		logic [SLOT_FIELD_W-1:0]     slot;
		logic [FILL_W-1:0]           fill_count;
		logic                        head_valid;
		logic signed [KEY_WIDTH-1:0] head_key;
		logic [TAG_WIDTH-1:0]        head_tag;
	} queue_report_t;

	// Shadow copy of the sorted store and its fill level
	logic signed [KEY_WIDTH-1:0] shadow_key [QUEUE_DEPTH];
	logic [TAG_WIDTH-1:0]        shadow_tag [QUEUE_DEPTH];
	int                          shadow_fill = 0;

	queue_report_t awaited_reports [$];
	queue_report_t oldest;
	queue_report_t predicted;

	initial begin
		mismatch_count = 0;
		outstanding    = 0;
		inserts_seen   = 0;
		drops_seen     = 0;
		clears_seen    = 0;
	end

	// Apply one request to the shadow store and work out the report it yields
	function automatic queue_report_t advance_shadow_queue(input logic op,
		input logic signed [KEY_WIDTH-1:0] key, input logic [TAG_WIDTH-1:0] tag);
		queue_report_t rep;
		int pos;
		int i;
		rep = '0;
		if (op == CMD_CLEAR) begin
			shadow_fill = 0;
			rep.status = STATUS_CLEARED;
		end else if (shadow_fill >= QUEUE_DEPTH) begin
			rep.status = STATUS_DROPPED;
		end else begin
			// skip every held entry whose key is not larger, so ties stay in arrival order
			pos = 0;
			while (pos < shadow_fill && shadow_key[pos] <= key)
				pos++;
			for (i = shadow_fill; i > pos; i--) begin
				shadow_key[i] = shadow_key[i-1];
				shadow_tag[i] = shadow_tag[i-1];
			end
			shadow_key[pos] = key;
			shadow_tag[pos] = tag;
			shadow_fill++;
			rep.status = STATUS_INSERTED;
			rep.slot = SLOT_FIELD_W'(pos);
		end
		rep.fill_count = FILL_W'(shadow_fill);
		if (shadow_fill > 0) begin
			rep.head_valid = 1'b1;
			rep.head_key = shadow_key[0];
			rep.head_tag = shadow_tag[0];
		end
		return rep;
	endfunction

	task automatic compare_field(input string field, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatch_count++;
		end
	endtask

	// Check result transactions first, then record the request taken at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (awaited_reports.size() == 0) begin
					$error("result transaction with no request outstanding");
					mismatch_count++;
				end else begin
					oldest = awaited_reports.pop_front();
					compare_field("status", oldest.status, rsp.status);
					compare_field("slot", oldest.slot, rsp.slot);
					compare_field("fill_count", oldest.fill_count, rsp.fill_count);
					compare_field("head_valid", oldest.head_valid, rsp.head_valid);
					compare_field("head_key", oldest.head_key, rsp.head_key);
					compare_field("head_tag", oldest.head_tag, rsp.head_tag);
				end
			end
			if (req.valid && req.ready) begin
				predicted = advance_shadow_queue(req.cmd, req.entry_key, req.entry_tag);
				awaited_reports.push_back(predicted);
				case (predicted.status)
					STATUS_INSERTED: inserts_seen++;
					STATUS_DROPPED:  drops_seen++;
					default:         clears_seen++;
				endcase
			end
		end
		outstanding <= awaited_reports.size();
	end

endmodule

// File: tb/tb_sorted_insert_priority_queue_unit.sv
`timescale 1ns / 1ps

module tb_sorted_insert_priority_queue_unit;
	import spq_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	int   sender_idle = 29;
	int   receiver_idle = 57;
	int   mismatch_count;
	int   outstanding;
	int   inserts_seen;
	int   drops_seen;
	int   clears_seen;

	spq_in_if  req_ch ();
	spq_out_if rsp_ch ();

	sorted_insert_priority_queue_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	sorted_queue_checker queue_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding),
		.inserts_seen   (inserts_seen),
		.drops_seen     (drops_seen),
		.clears_seen    (clears_seen)
	);

	always #10 clk = ~clk;

	// Stall the result side at random
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= receiver_idle);
	end

	// Offer one request transaction, with a random gap first, and hold it until taken
	task automatic offer_request(input logic op, input logic signed [KEY_WIDTH-1:0] key,
		input logic [TAG_WIDTH-1:0] tag);
		if ($urandom_range(99) < sender_idle) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle);
		end
		req_ch.valid     <= 1'b1;
		req_ch.cmd       <= op;
		req_ch.entry_key <= key;
		req_ch.entry_tag <= tag;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Hold off the sender until every outstanding result has been taken
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Bursts of inserts, each closed by a clear; long bursts fill the queue and drop
	task automatic run_random_phase(input int n_items);
		int sent;
		int burst;
		logic signed [KEY_WIDTH-1:0] key;
		sent = 0;
		while (sent < n_items) begin
			burst = $urandom_range(24, 0);
			repeat (burst) begin
				case ($urandom_range(4))
					0, 1: key = KEY_WIDTH'($urandom_range(8)) - KEY_WIDTH'(4);
					2: begin
						case ($urandom_range(3))
							0: key = 16'sh8000;
							1: key = 16'sh7FFF;
							2: key = '0;
							default: key = '1;
						endcase
					end
					default: key = KEY_WIDTH'($urandom);
				endcase
				offer_request(CMD_INSERT, key, TAG_WIDTH'($urandom));
				sent++;
			end
			// key and tag of a clear are ignored, so send noise there
			offer_request(CMD_CLEAR, KEY_WIDTH'($urandom), TAG_WIDTH'($urandom));
			sent++;
		end
	endtask

	initial begin : stimulus
		logic signed [KEY_WIDTH-1:0] fill_keys [QUEUE_DEPTH];
		int k;
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.cmd       = CMD_INSERT;
		req_ch.entry_key = '0;
		req_ch.entry_tag = '0;
		rsp_ch.ready     = 1'b0;
		fill_keys = '{16'sd0, 16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0, -16'sd1, 16'sd1, 16'sh5555,
			16'shAAAA, 16'sh7FFF, 16'sh8000, 16'sd100, -16'sd100, 16'sd7, 16'sd7, 16'sd7};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Clear on an empty queue, fill with extremes and ties, overflow, clear twice, insert once
		offer_request(CMD_CLEAR, '0, '0);
		for (k = 0; k < QUEUE_DEPTH; k++)
			offer_request(CMD_INSERT, fill_keys[k], TAG_WIDTH'(k * 17));
		offer_request(CMD_INSERT, 16'sh8000, 8'hFF);
		offer_request(CMD_INSERT, 16'sh7FFF, 8'h00);
		offer_request(CMD_CLEAR, '1, '1);
		offer_request(CMD_CLEAR, '0, '0);
		offer_request(CMD_INSERT, '1, 8'h5A);
		drain_results();

		run_random_phase(280);
		drain_results();

		sender_idle   = 57;
		receiver_idle = 29;
		run_random_phase(280);
		drain_results();

		sender_idle   = 0;
		receiver_idle = 0;
		run_random_phase(270);
		drain_results();

		// Give a stray late result time to show up
		repeat (8) @(posedge clk);
		$display("Covered %0d inserts, %0d drops on a full queue and %0d clears,",
			inserts_seen, drops_seen, clears_seen);
		$display("under three sender and receiver stall mixes.");
		if (mismatch_count == 0 && outstanding == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Abort a hung run
	initial begin
		#4_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_in_if.sv
rtl/spq_out_if.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/sorted_insert_priority_queue_unit.sv
tb/sorted_queue_checker.sv
tb/tb_sorted_insert_priority_queue_unit.sv
